@@ src/uq16b_pkg.sv @@
// ----------------------------------------------------------------------------
// uq16b_pkg
// Shared types, constants and the pixel conversion for the Q2.16 unpacker.
// ----------------------------------------------------------------------------
package uq16b_pkg;

   localparam int COUNT_BITS = 24;
   localparam int WORD_BITS  = 32;
   localparam int VALUE_BITS = 18;
   localparam int CARRY_BITS = 14;
   localparam int PIXEL_BITS = 8;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef enum logic [1:0] {
      PHASE_W0 = 2'd0,
      PHASE_W1 = 2'd1,
      PHASE_W2 = 2'd2,
      PHASE_W3 = 2'd3
   } phase_type;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } beat_type;

   // Negative values clamp to 0, values of 1.0 or more to 255, the rest
   // scale by 255 and drop the 16 fraction bits.
   function automatic pixel_type to_pixel(input value_type v);
      logic [23:0] prod;
      prod = {v[15:0], 8'h00} - {8'h00, v[15:0]};
      if (v[VALUE_BITS-1]) begin
         to_pixel = '0;
      end else if (v[16]) begin
         to_pixel = '1;
      end else begin
         to_pixel = prod[23:16];
      end
   endfunction

endpackage

@@ src/unpack_q16_18bit_to_byte.sv @@
// ----------------------------------------------------------------------------
// unpack_q16_18bit_to_byte
// Unpacks seven signed 18-bit Q2.16 values from each group of four 32-bit
// words and converts every value to a clamped 8-bit pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Words enter on the req_ channel (valid/ready), in group order 0 to 3.
//   Pixels leave on the rsp_ channel (valid/ready), one beat per pixel, with
//   rsp_last marking value number csr_total_values of the transfer.
//   csr_wr_en loads the value count; write it only while the block is idle.
//   An accepted word is first held in the input register, then decoded
//   combinationally into a two-entry result buffer once that buffer is
//   empty or holds only a beat that is being taken; its first pixel is
//   offered from there. Throughput: the result buffer drains one beat per
//   cycle while the receiver is ready. A new word is taken while a result
//   still waits in the buffer.
//   Reset clears the group phase, the carry bits and the value counter and
//   sets the count to 1. When the receiver stalls, the buffer holds, the
//   input register fills, and req_ready drops until beats are taken again.
// ----------------------------------------------------------------------------
module unpack_q16_18bit_to_byte (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_data_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_pixel,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [uq16b_pkg::COUNT_BITS-1:0] csr_total_values
);

   logic                          word_valid_ff;
   logic [31:0]                   word_ff;
   uq16b_pkg::phase_type          phase_ff;
   uq16b_pkg::phase_type          phase_in;
   logic [uq16b_pkg::CARRY_BITS-1:0] carry_ff;
   logic [uq16b_pkg::CARRY_BITS-1:0] carry_in;
   uq16b_pkg::count_type          total_ff;
   uq16b_pkg::count_type          done_ff;
   uq16b_pkg::count_type          done_in;
   uq16b_pkg::count_type          done_a;
   uq16b_pkg::count_type          done_b;
   uq16b_pkg::beat_type           slot0_ff;
   uq16b_pkg::beat_type           slot0_in;
   uq16b_pkg::beat_type           slot1_ff;
   uq16b_pkg::beat_type           slot1_in;
   logic [1:0]                    fill_ff;
   logic [1:0]                    fill_in;
   uq16b_pkg::value_type          value_a;
   uq16b_pkg::value_type          value_b;
   uq16b_pkg::beat_type           beat_a;
   uq16b_pkg::beat_type           beat_b;
   logic                          has_a;
   logic                          emit_a;
   logic                          emit_b;
   logic                          pop;
   logic                          advance;

   assign pop       = rsp_valid && rsp_ready;
   assign advance   = word_valid_ff && ((fill_ff == 2'd0) || ((fill_ff == 2'd1) && pop));
   assign req_ready = !word_valid_ff || advance;

   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_pixel = slot0_ff.pixel;
   assign rsp_last  = slot0_ff.last;

   always_comb begin
      has_a    = 1'b1;
      value_a  = '0;
      value_b  = '0;
      carry_in = '0;
      phase_in = uq16b_pkg::PHASE_W0;
      unique case (phase_ff)
         uq16b_pkg::PHASE_W0: begin
            has_a    = 1'b0;
            value_b  = word_ff[17:0];
            carry_in = word_ff[31:18];
            phase_in = uq16b_pkg::PHASE_W1;
         end
         uq16b_pkg::PHASE_W1: begin
            value_a  = {word_ff[3:0], carry_ff};
            value_b  = word_ff[21:4];
            carry_in = {4'h0, word_ff[31:22]};
            phase_in = uq16b_pkg::PHASE_W2;
         end
         uq16b_pkg::PHASE_W2: begin
            value_a  = {word_ff[7:0], carry_ff[9:0]};
            value_b  = word_ff[25:8];
            carry_in = {8'h00, word_ff[31:26]};
            phase_in = uq16b_pkg::PHASE_W3;
         end
         uq16b_pkg::PHASE_W3: begin
            value_a  = {word_ff[11:0], carry_ff[5:0]};
            value_b  = word_ff[29:12];
            carry_in = '0;
            phase_in = uq16b_pkg::PHASE_W0;
         end
         default: begin
            has_a = 1'b0;
         end
      endcase
   end

   always_comb begin
      emit_a       = has_a && (done_ff < total_ff);
      done_a       = emit_a ? done_ff + 1'b1 : done_ff;
      emit_b       = (done_a < total_ff);
      done_b       = emit_b ? done_a + 1'b1 : done_a;
      beat_a.pixel = uq16b_pkg::to_pixel(value_a);
      beat_a.last  = (done_a == total_ff);
      beat_b.pixel = uq16b_pkg::to_pixel(value_b);
      beat_b.last  = (done_b == total_ff);
      done_in      = done_b;
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (advance) begin
         slot0_in = emit_a ? beat_a : beat_b;
         slot1_in = beat_b;
         fill_in  = {1'b0, emit_a} + {1'b0, emit_b};
      end else if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         phase_ff      <= uq16b_pkg::PHASE_W0;
         carry_ff      <= '0;
         done_ff       <= '0;
         total_ff      <= uq16b_pkg::count_type'(1);
         fill_ff       <= 2'd0;
      end else begin
         if (req_ready) begin
            word_valid_ff <= req_valid;
         end
         if (advance) begin
            phase_ff <= phase_in;
            carry_ff <= carry_in;
            done_ff  <= done_in;
         end
         if (csr_wr_en) begin
            total_ff <= csr_total_values;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         word_ff <= req_data_word;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ src/uq16b_checker.sv @@
// ----------------------------------------------------------------------------
// uq16b_checker
// Port-level checks for the Q2.16 unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module uq16b_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_pixel,
   input logic        rsp_last
);

   // A stalled beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // The block comes out of reset with nothing to deliver.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // The final pixel of a transfer is never followed directly by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result offered after the final pixel");

   // Input back-pressure only arises while results are waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind unpack_q16_18bit_to_byte uq16b_checker u_uq16b_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_pixel (rsp_pixel),
   .rsp_last  (rsp_last)
);
